### sv/ftcb_pkg.sv
package ftcb_pkg;

  localparam logic [2:0] OP_FRAME = 3'd0;
  localparam logic [2:0] OP_SNAP  = 3'd1;
  localparam logic [2:0] OP_DROPS = 3'd2;
  localparam logic [2:0] OP_READ  = 3'd3;
  localparam logic [2:0] OP_CLEAR = 3'd4;

  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_CAPT   = 2'd1;
  localparam logic [1:0] MODE_FROZEN = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_REJ   = 2'd1;
  localparam logic [1:0] ST_UNAV  = 2'd2;

  localparam logic [2:0] REG_PRE    = 3'd0;
  localparam logic [2:0] REG_POST   = 3'd1;
  localparam logic [2:0] REG_REASON = 3'd2;
  localparam logic [2:0] REG_HASH   = 3'd3;
  localparam logic [2:0] REG_KIND   = 3'd4;

  localparam int unsigned HDR_LEN = 21;
  localparam logic [31:0] CRC_POLY = 32'hEDB88320;

  typedef struct packed {
    logic [2:0]  operation;
    logic [7:0]  data_byte;
    logic [7:0]  frame_length;
    logic        first_of_frame;
    logic        is_fault;
    logic [31:0] drop_amount;
    logic [15:0] max_read_len;
  } item_t;

  typedef struct packed {
    logic       last_byte;
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       captured;
    logic [1:0] mode;
  } result_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      r = (r >> 1) ^ (CRC_POLY & {32{r[0]}});
    end
    return r;
  endfunction

endpackage

### sv/ftcb_core.sv
module ftcb_core #(
  parameter int RING_BYTES      = 1024,
  parameter int MAX_FRAME_BYTES = 64,
  parameter int SNAPSHOT_BYTES  = 32,
  parameter int MAX_FRAMES      = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  ftcb_pkg::item_t  item_i,
  input  logic [7:0]       pre_limit_i,
  input  logic [7:0]       post_limit_i,
  input  logic [7:0]       reason_i,
  input  logic [31:0]      hash_i,
  input  logic [7:0]       kind_i,
  output logic             done_o,
  output ftcb_pkg::result_t res_o,
  output logic             busy_o
);
  import ftcb_pkg::*;

  localparam int RW = $clog2(RING_BYTES);
  localparam int UW = $clog2(RING_BYTES + 1);
  localparam int FW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int HW = $clog2(MAX_FRAMES + 1);
  localparam int SD = (SNAPSHOT_BYTES > 0) ? SNAPSHOT_BYTES : 1;
  localparam int SW = (SD > 1) ? $clog2(SD) : 1;
  localparam int CW = $clog2(SNAPSHOT_BYTES + 2);
  localparam logic [2:0] S_IDLE = 3'd0, S_EVR = 3'd1, S_EVX = 3'd2, S_RD = 3'd3,
                         S_TRIM = 3'd4;

  logic [7:0] ring_mem [RING_BYTES];
  logic [7:0] len_mem  [MAX_FRAMES];
  logic [7:0] snap_mem [SD];
  logic [7:0] ring_rd_q, len_rd_q, snap_rd_q;

  logic [2:0]  st_q, st_d;
  item_t       it_q;
  logic [RW-1:0] head_q, head_d;
  logic [UW-1:0] used_q, used_d;
  logic [HW-1:0] held_q, held_d;
  logic [FW-1:0] old_q, old_d;
  logic [7:0]  pre_q, pre_d, post_q, post_d, fk_q, fk_d, rr_q, rr_d, decl_q, decl_d;
  logic [7:0]  idx_q, idx_d;
  logic [CW-1:0] sc_q, sc_d;
  logic [31:0] drop_q, drop_d, crc_q, crc_d;
  logic [1:0]  mode_q, mode_d;
  logic        acc_q, acc_d, ffo_q, ffo_d;
  logic [15:0] rp_q, rp_d;

  logic        ring_we, len_we, snap_we;
  logic [RW-1:0] ring_wa, ring_ra;
  logic [FW-1:0] len_wa, len_ra;
  logic [SW-1:0] snap_wa, snap_ra;
  logic [7:0]  ring_wd, len_wd;
  logic        done_d;
  result_t     res_d;

  // the item is held at the input for the whole operation
  assign it_q = item_i;

  always_ff @(posedge clk_i) begin
    if (ring_we) ring_mem[ring_wa] <= ring_wd;
    if (len_we) len_mem[len_wa] <= len_wd;
    if (snap_we) snap_mem[snap_wa] <= it_q.data_byte;
    ring_rd_q <= ring_mem[ring_ra];
    len_rd_q  <= len_mem[len_ra];
    snap_rd_q <= snap_mem[snap_ra];
  end

  logic [16:0] total;
  logic [16:0] p_snap, p_ring;
  logic [7:0]  hdr_b;
  logic [UW:0] need;
  logic [7:0]  ev_len;
  logic        fits_len, full_f;
  logic [FW-1:0] tail_slot, last_slot;

  always_comb begin
    total = 17'(HDR_LEN) + 17'(sc_q) + 17'(used_q) + 17'd4;
    p_snap = 17'(rp_q) - 17'(HDR_LEN);
    p_ring = p_snap - 17'(sc_q);
    need = (UW+1)'(used_q) + (UW+1)'(it_q.frame_length);
    fits_len = (32'(it_q.frame_length) <= 32'(MAX_FRAME_BYTES)) &&
               (32'(it_q.frame_length) <= 32'(RING_BYTES));
    full_f = 32'(held_q) >= 32'(MAX_FRAMES);
    tail_slot = FW'((32'(old_q) + 32'(held_q)) % MAX_FRAMES);
    last_slot = FW'((32'(old_q) + 32'(held_q) + MAX_FRAMES - 1) % MAX_FRAMES);
    ev_len = (32'(len_rd_q) > 32'(used_q)) ? 8'(used_q) : len_rd_q;
    case (rp_q[4:0])
      5'd0: hdr_b = 8'h41;
      5'd1: hdr_b = 8'h58;
      5'd2: hdr_b = 8'h43;
      5'd3: hdr_b = 8'h50;
      5'd4: hdr_b = 8'd1;
      5'd5: hdr_b = total[7:0];
      5'd6: hdr_b = total[15:8];
      5'd7: hdr_b = rr_q;
      5'd8: hdr_b = fk_q;
      5'd9: hdr_b = hash_i[31:24];
      5'd10: hdr_b = hash_i[23:16];
      5'd11: hdr_b = hash_i[15:8];
      5'd12: hdr_b = hash_i[7:0];
      5'd13: hdr_b = drop_q[7:0];
      5'd14: hdr_b = drop_q[15:8];
      5'd15: hdr_b = drop_q[23:16];
      5'd16: hdr_b = drop_q[31:24];
      5'd17: hdr_b = pre_q;
      5'd18: hdr_b = post_q;
      5'd19: hdr_b = kind_i;
      5'd20: hdr_b = 8'(sc_q);
      default: hdr_b = 8'd0;
    endcase
  end

  logic        avail;
  assign avail = (mode_q != MODE_IDLE) && (post_q != 8'd0);

  always_comb begin
    logic ok, st1, evict_more;
    logic [7:0] b;
    st_d = st_q; head_d = head_q; used_d = used_q; held_d = held_q; old_d = old_q;
    pre_d = pre_q; post_d = post_q; fk_d = fk_q; rr_d = rr_q; decl_d = decl_q;
    idx_d = idx_q; sc_d = sc_q; drop_d = drop_q; crc_d = crc_q; mode_d = mode_q;
    acc_d = acc_q; ffo_d = ffo_q; rp_d = rp_q;
    ring_we = 1'b0; len_we = 1'b0; snap_we = 1'b0;
    ring_wa = RW'((32'(head_q) + 32'(used_q)) % RING_BYTES);
    ring_wd = it_q.data_byte;
    len_wa = tail_slot; len_wd = it_q.frame_length;
    ring_ra = RW'((32'(head_q) + 32'(p_ring)) % RING_BYTES);
    len_ra = old_q;
    snap_ra = SW'(32'(p_snap) % SD);
    snap_wa = SW'(32'(sc_q) % SD);
    done_d = 1'b0;
    res_d = '0;
    ok = 1'b0; st1 = 1'b0; b = 8'd0;
    evict_more = (held_q != '0) && ((pre_q >= pre_limit_i) ||
                 (need > (UW+1)'(RING_BYTES)) || full_f);
    case (st_q)
      S_IDLE: begin
        if (start_i) begin
          case (it_q.operation)
            OP_FRAME: begin
              if (it_q.first_of_frame && acc_q && (idx_q < decl_q) && (held_q != '0)) begin
                len_we = 1'b1; len_wa = last_slot; len_wd = idx_q;
                st_d = S_TRIM;
              end else begin
                st_d = S_TRIM;
              end
            end
            OP_READ: begin
              if (!avail || (17'(it_q.max_read_len) < total) || (total > 17'hFFFF)) begin
                rp_d = '0; crc_d = '1;
                res_d.status = ST_UNAV; res_d.last_byte = 1'b1; done_d = 1'b1;
              end else begin
                if (17'(rp_q) >= total) begin rp_d = '0; crc_d = '1; end
                st_d = S_RD;
              end
            end
            OP_SNAP: begin
              if (mode_q != MODE_IDLE && 32'(sc_q) < SNAPSHOT_BYTES) begin
                snap_we = 1'b1; sc_d = sc_q + 1'b1;
              end else res_d.status = ST_REJ;
              done_d = 1'b1;
            end
            OP_DROPS: begin drop_d = drop_q + it_q.drop_amount; done_d = 1'b1; end
            OP_CLEAR: begin
              head_d = '0; used_d = '0; held_d = '0; old_d = '0; pre_d = '0; post_d = '0;
              sc_d = '0; fk_d = '0; rr_d = '0; drop_d = '0; mode_d = MODE_IDLE;
              idx_d = '0; rp_d = '0; crc_d = '1; acc_d = 1'b0; decl_d = '0; ffo_d = 1'b0;
              done_d = 1'b1;
            end
            default: begin res_d.status = ST_REJ; done_d = 1'b1; end
          endcase
        end
      end
      S_TRIM: begin
        // frame byte: open a frame on the first beat, then store
        st_d = S_IDLE;
        done_d = 1'b1;
        st1 = 1'b0;
        if (it_q.first_of_frame) begin
          acc_d = 1'b0; ffo_d = 1'b0; decl_d = it_q.frame_length; idx_d = '0;
          if (it_q.frame_length == 8'd0) begin
            res_d.status = ST_REJ;
          end else if (mode_q == MODE_IDLE && !it_q.is_fault) begin
            if (pre_limit_i == 8'd0 || !fits_len) begin
              st1 = 1'b1;
            end else if (evict_more) begin
              done_d = 1'b0; st_d = S_EVR;
            end else begin
              st1 = 1'b1;
              if (!(need > (UW+1)'(RING_BYTES)) && !full_f) begin
                len_we = 1'b1; held_d = held_q + 1'b1;
                if (pre_q != 8'hFF) pre_d = pre_q + 1'b1;
                ok = 1'b1;
              end
            end
          end else begin
            st1 = 1'b1;
            if (mode_q == MODE_IDLE) begin
              mode_d = MODE_CAPT; rr_d = reason_i; fk_d = '0; sc_d = '0; ffo_d = 1'b1;
            end
            if (mode_q == MODE_IDLE || (mode_q == MODE_CAPT && post_q < post_limit_i)) begin
              if (!fits_len || need > (UW+1)'(RING_BYTES) || full_f) begin
                mode_d = MODE_FROZEN;
              end else begin
                len_we = 1'b1; held_d = held_q + 1'b1;
                if (post_q != 8'hFF) post_d = post_q + 1'b1;
                ok = 1'b1;
              end
            end
            if (mode_d == MODE_CAPT && post_d >= post_limit_i) mode_d = MODE_FROZEN;
          end
          if (st1) acc_d = ok;
        end else if (idx_q >= decl_q) begin
          res_d.status = ST_REJ;
        end else begin
          st1 = 1'b1; ok = acc_q;
        end
        if (st1) begin
          if (ffo_d && idx_d == 8'd3) fk_d = it_q.data_byte;
          if (ok && 32'(used_d) < RING_BYTES) begin
            ring_we = 1'b1;
            ring_wa = RW'((32'(head_d) + 32'(used_d)) % RING_BYTES);
            used_d = used_d + 1'b1;
          end
          idx_d = idx_d + 1'b1;
          res_d.status = ok ? ST_OK : ST_REJ;
        end
      end
      S_EVR: st_d = S_EVX;   // length memory read in flight
      S_EVX: begin
        head_d = RW'((32'(head_q) + 32'(ev_len)) % RING_BYTES);
        used_d = used_q - UW'(ev_len);
        old_d = FW'((32'(old_q) + 1) % MAX_FRAMES);
        held_d = held_q - 1'b1;
        if (pre_q != 8'd0) pre_d = pre_q - 1'b1;
        st_d = S_TRIM;
      end
      S_RD: begin
        st_d = S_IDLE; done_d = 1'b1;
        if (17'(rp_q) < total - 17'd4) begin
          if (rp_q < 16'(HDR_LEN)) b = hdr_b;
          else if (p_snap < 17'(sc_q)) b = snap_rd_q;
          else b = ring_rd_q;
          crc_d = crc_byte(crc_q, b);
        end else begin
          case (2'(17'(rp_q) - (total - 17'd4)))
            2'd0: b = ~crc_q[7:0];
            2'd1: b = ~crc_q[15:8];
            2'd2: b = ~crc_q[23:16];
            default: b = ~crc_q[31:24];
          endcase
        end
        res_d.out_byte = b;
        if (17'(rp_q) == total - 17'd1) begin
          res_d.last_byte = 1'b1; rp_d = '0; crc_d = '1;
        end else rp_d = rp_q + 1'b1;
      end
      default: st_d = S_IDLE;
    endcase
    res_d.mode = mode_d;
    res_d.captured = (mode_d != MODE_IDLE) && (post_d != 8'd0);
  end

  // S_EVX returns to S_TRIM, which re-runs the start checks with the item held
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; head_q <= '0; used_q <= '0; held_q <= '0; old_q <= '0;
      pre_q <= '0; post_q <= '0; fk_q <= '0; rr_q <= '0; decl_q <= '0; idx_q <= '0;
      sc_q <= '0; drop_q <= '0; crc_q <= '1; mode_q <= MODE_IDLE; acc_q <= 1'b0;
      ffo_q <= 1'b0; rp_q <= '0; done_o <= 1'b0;
    end else begin
      st_q <= st_d; head_q <= head_d; used_q <= used_d; held_q <= held_d;
      old_q <= old_d; pre_q <= pre_d; post_q <= post_d; fk_q <= fk_d; rr_q <= rr_d;
      decl_q <= decl_d; idx_q <= idx_d; sc_q <= sc_d; drop_q <= drop_d; crc_q <= crc_d;
      mode_q <= mode_d; acc_q <= acc_d; ffo_q <= ffo_d; rp_q <= rp_d; done_o <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done_d) res_o <= res_d;
  end

  assign busy_o = (st_q != S_IDLE);
endmodule

### sv/fault_trace_capsule_buffer_top.sv
// Flow: an accepted beat is registered before the core starts it; most operations and an
// unavailable read finish in S_IDLE, a read passes through S_RD and every frame beat through
// S_TRIM, and each oldest frame evicted before a new pre-fault frame opens adds S_EVR and S_EVX.
// Throughput: one input beat at a time; a new beat is taken once the result is taken.
// Reset: asynchronous active low; clears all counters, mode idle, CRC all ones,
// registers to defaults. Ring, length and snapshot memories are not cleared.
module fault_trace_capsule_buffer_top #(
  parameter int RING_BYTES      = 1024,
  parameter int MAX_FRAME_BYTES = 64,
  parameter int SNAPSHOT_BYTES  = 32,
  parameter int MAX_FRAMES      = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // data_byte[7:0], frame_length[15:8], drop_amount[47:16], max_read_len[63:48]
  input  logic [63:0] s_axis_tdata,
  // operation[2:0], first_of_frame[3], is_fault[4]
  input  logic [4:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_byte[7:0], status[9:8], captured[10], mode[12:11]
  output logic [15:0] m_axis_tdata,
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import ftcb_pkg::*;

  logic [7:0]  pre_q, post_q, reason_q, kind_q;
  logic [31:0] hash_q;
  logic        pend_q, start, done, busy;
  item_t       item;
  item_t       item_hold;
  result_t     res;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_q <= 8'd16; post_q <= 8'd16; reason_q <= '0; hash_q <= '0; kind_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_PRE:    pre_q <= cfg_data_i[7:0];
        REG_POST:   post_q <= cfg_data_i[7:0];
        REG_REASON: reason_q <= cfg_data_i[7:0];
        REG_HASH:   hash_q <= cfg_data_i;
        REG_KIND:   kind_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign item = '{operation: s_axis_tuser[2:0], data_byte: s_axis_tdata[7:0],
                  frame_length: s_axis_tdata[15:8], first_of_frame: s_axis_tuser[3],
                  is_fault: s_axis_tuser[4], drop_amount: s_axis_tdata[47:16],
                  max_read_len: s_axis_tdata[63:48]};

  logic go_q;
  assign s_axis_tready = !pend_q && !busy && !go_q && !m_axis_tvalid;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      go_q <= 1'b0; pend_q <= 1'b0; m_axis_tvalid <= 1'b0;
    end else begin
      go_q <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) pend_q <= 1'b1;
      else if (done) pend_q <= 1'b0;
      if (done) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
    end
  end
  assign start = go_q;

  // hold the accepted beat until its result has been taken
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) item_hold <= item;
  end

  ftcb_core #(.RING_BYTES(RING_BYTES), .MAX_FRAME_BYTES(MAX_FRAME_BYTES),
              .SNAPSHOT_BYTES(SNAPSHOT_BYTES), .MAX_FRAMES(MAX_FRAMES)) u_core (
    .clk_i, .rst_ni, .start_i(start), .item_i(item_hold),
    .pre_limit_i(pre_q), .post_limit_i(post_q), .reason_i(reason_q),
    .hash_i(hash_q), .kind_i(kind_q), .done_o(done), .res_o(res), .busy_o(busy));

  assign m_axis_tdata = {3'd0, res.mode, res.captured, res.status, res.out_byte};
  assign m_axis_tlast = res.last_byte;
endmodule

### sv/ftcb_checker.sv
module ftcb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tlast
);
  a_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[12:11] != 2'd3) else $error("bad mode");
  a_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[10] |-> m_axis_tdata[12:11] != 2'd0)
    else $error("capture while idle");
  a_unav: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[9:8] == 2'd2 |-> m_axis_tlast && m_axis_tdata[7:0] == 8'd0)
    else $error("unavailable read shape");
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |-> !m_axis_tvalid) else $error("overlap");
endmodule

bind fault_trace_capsule_buffer_top ftcb_checker u_chk (.*);

### tb/fault_trace_capsule_buffer_top_tb.sv
`timescale 1ns / 1ps

module fault_trace_capsule_buffer_top_tb;
  import ftcb_pkg::*;

  localparam int RING  = 1024;
  localparam int MAXFB = 64;
  localparam int SNAPB = 32;
  localparam int MAXFR = 64;
  localparam logic [2:0] OP_RSVD5 = 3'd5;
  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;
  localparam int ITEM_GOAL = 1750;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic [4:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  fault_trace_capsule_buffer_top dut (.*);

  initial forever #2 clk_i = ~clk_i;

  // register copies
  logic [7:0]  pre_lim, post_lim, reason_reg, kind_reg;
  logic [31:0] hash_reg;

  // capture state as the block should hold it
  logic [7:0]  ring_mem [RING];
  logic [7:0]  len_mem  [MAXFR];
  logic [7:0]  snap_mem [SNAPB + 1];
  int unsigned ring_head, ring_used, held, pre_cnt, post_cnt, snap_cnt;
  int unsigned fifo_first, declared, byte_idx, read_pos;
  logic [7:0]  fault_type, reason_latched;
  logic [31:0] drops_total, crc_run;
  logic [1:0]  cap_mode;
  bit          accepting, fault_open;

  item_t   pending_items_q [$];
  result_t expected_results_q [$];
  item_t   cur_item;
  int      items_queued = 0;
  int      fails = 0;
  int      burst_left = 0, gap_left = 0;
  int      hold_req = 0, hold_seen = 0, hold_left = 0;
  int      ready_style = 0, style_left = 0;

  function automatic void clear_capture();
    ring_head = 0; ring_used = 0; held = 0; pre_cnt = 0; post_cnt = 0;
    snap_cnt = 0; fault_type = '0; reason_latched = '0; drops_total = '0;
    cap_mode = MODE_IDLE; byte_idx = 0; read_pos = 0; crc_run = '1;
    accepting = 0; fifo_first = 0; declared = 0; fault_open = 0;
  endfunction

  function automatic void push_len(int unsigned n);
    len_mem[(fifo_first + held) % MAXFR] = n[7:0];
    held++;
  endfunction

  function automatic void evict_oldest();
    int unsigned n;
    n = len_mem[fifo_first];
    if (n > ring_used) n = ring_used;
    ring_head = (ring_head + n) % RING;
    ring_used -= n;
    fifo_first = (fifo_first + 1) % MAXFR;
    held--;
    if (pre_cnt > 0) pre_cnt--;
  endfunction

  function automatic bit retain_pre(int unsigned n);
    if (pre_lim == 0 || n > MAXFB) return 0;
    while (held > 0 && (pre_cnt >= pre_lim || ring_used + n > RING || held >= MAXFR))
      evict_oldest();
    if (ring_used + n > RING || held >= MAXFR) return 0;
    push_len(n);
    if (pre_cnt < 255) pre_cnt++;
    return 1;
  endfunction

  function automatic bit append_post(int unsigned n);
    if (n > MAXFB || ring_used + n > RING || held >= MAXFR) begin
      cap_mode = MODE_FROZEN;
      return 0;
    end
    push_len(n);
    if (post_cnt < 255) post_cnt++;
    return 1;
  endfunction

  function automatic bit open_frame(int unsigned n, bit fault);
    bit ok;
    ok = 0;
    if (cap_mode == MODE_IDLE) begin
      if (!fault) return retain_pre(n);
      cap_mode = MODE_CAPT;
      reason_latched = reason_reg;
      fault_type = '0;
      snap_cnt = 0;
      fault_open = 1;
      ok = append_post(n);
    end else if (cap_mode == MODE_CAPT && post_cnt < post_lim) begin
      ok = append_post(n);
    end
    if (cap_mode == MODE_CAPT && post_cnt >= post_lim) cap_mode = MODE_FROZEN;
    return ok;
  endfunction

  function automatic logic [1:0] take_frame_byte(logic [7:0] b, int unsigned n, bit first,
                                                 bit fault);
    if (first) begin
      // trim a frame that ended short
      if (accepting && byte_idx < declared && held > 0)
        len_mem[(fifo_first + held - 1) % MAXFR] = byte_idx[7:0];
      accepting = 0;
      fault_open = 0;
      declared = n;
      byte_idx = 0;
      if (n == 0) return ST_REJ;
      accepting = open_frame(n, fault);
    end else if (byte_idx >= declared) begin
      return ST_REJ;
    end
    if (fault_open && byte_idx == 3) fault_type = b;
    if (accepting && ring_used < RING) begin
      ring_mem[(ring_head + ring_used) % RING] = b;
      ring_used++;
    end
    byte_idx++;
    return accepting ? ST_OK : ST_REJ;
  endfunction

  function automatic logic [7:0] image_at(int unsigned p, int unsigned total);
    case (p)
      0: return 8'h41;
      1: return 8'h58;
      2: return 8'h43;
      3: return 8'h50;
      4: return 8'd1;
      5: return total[7:0];
      6: return total[15:8];
      7: return reason_latched;
      8: return fault_type;
      9: return hash_reg[31:24];
      10: return hash_reg[23:16];
      11: return hash_reg[15:8];
      12: return hash_reg[7:0];
      13: return drops_total[7:0];
      14: return drops_total[15:8];
      15: return drops_total[23:16];
      16: return drops_total[31:24];
      17: return pre_cnt[7:0];
      18: return post_cnt[7:0];
      19: return kind_reg;
      20: return snap_cnt[7:0];
      default: ;
    endcase
    p -= HDR_LEN;
    if (p < snap_cnt) return snap_mem[p];
    p -= snap_cnt;
    return ring_mem[(ring_head + p) % RING];
  endfunction

  function automatic result_t capsule_next_result(item_t it);
    result_t     r;
    int unsigned total;
    logic [31:0] inv;
    r = '0;
    case (it.operation)
      OP_FRAME: r.status = take_frame_byte(it.data_byte, it.frame_length,
                                           it.first_of_frame, it.is_fault);
      OP_SNAP: begin
        if (cap_mode != MODE_IDLE && snap_cnt < SNAPB) begin
          snap_mem[snap_cnt] = it.data_byte;
          snap_cnt++;
        end else begin
          r.status = ST_REJ;
        end
      end
      OP_DROPS: drops_total = drops_total + it.drop_amount;
      OP_READ: begin
        total = HDR_LEN + snap_cnt + ring_used + 4;
        if (cap_mode == MODE_IDLE || post_cnt == 0 || total > it.max_read_len ||
            total > 16'hFFFF) begin
          read_pos = 0;
          crc_run = '1;
          r.status = ST_UNAV;
          r.last_byte = 1'b1;
        end else begin
          if (read_pos >= total) begin
            read_pos = 0;
            crc_run = '1;
          end
          if (read_pos < total - 4) begin
            r.out_byte = image_at(read_pos, total);
            crc_run ^= {24'd0, r.out_byte};
            for (int i = 0; i < 8; i++)
              crc_run = crc_run[0] ? ((crc_run >> 1) ^ CRC_POLY) : (crc_run >> 1);
          end else begin
            inv = ~crc_run;
            r.out_byte = inv >> (8 * (read_pos - (total - 4)));
          end
          if (read_pos == total - 1) begin
            r.last_byte = 1'b1;
            read_pos = 0;
            crc_run = '1;
          end else begin
            read_pos++;
          end
        end
      end
      OP_CLEAR: clear_capture();
      default: r.status = ST_REJ;
    endcase
    r.captured = (cap_mode != MODE_IDLE) && (post_cnt > 0);
    r.mode = cap_mode;
    return r;
  endfunction

  // sender: bursts and gaps, predict on every accepted beat
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        expected_results_q.push_back(capsule_next_result(cur_item));
      if (s_axis_tvalid && !s_axis_tready) begin
        // hold the beat
      end else if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_items_q.size() > 0) begin
        cur_item = pending_items_q.pop_front();
        s_axis_tdata <= {cur_item.max_read_len, cur_item.drop_amount,
                         cur_item.frame_length, cur_item.data_byte};
        s_axis_tuser <= {cur_item.is_fault, cur_item.first_of_frame, cur_item.operation};
        s_axis_tvalid <= 1'b1;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
        end else begin
          burst_left--;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern of its own, plus a long hold on request
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = 400;
      end
      if (style_left == 0) begin
        ready_style = $urandom_range(0, 2);
        style_left = $urandom_range(16, 96);
      end else begin
        style_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (ready_style)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= $urandom_range(0, 1);
          default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic report(string field, int unsigned exp_v, int unsigned got_v);
    $display("%0t mismatch %s: expected %0h got %0h", $time, field, exp_v, got_v);
    fails++;
  endtask

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_results_q.size() == 0) begin
        $display("%0t unexpected result beat %0h", $time, m_axis_tdata);
        fails++;
      end else begin
        want = expected_results_q.pop_front();
        if (m_axis_tdata[7:0] !== want.out_byte) report("out_byte", want.out_byte,
                                                         m_axis_tdata[7:0]);
        if (m_axis_tdata[9:8] !== want.status) report("status", want.status,
                                                       m_axis_tdata[9:8]);
        if (m_axis_tdata[10] !== want.captured) report("captured", want.captured,
                                                        m_axis_tdata[10]);
        if (m_axis_tdata[12:11] !== want.mode) report("mode", want.mode,
                                                       m_axis_tdata[12:11]);
        if (m_axis_tlast !== want.last_byte) report("last_byte", want.last_byte,
                                                     m_axis_tlast);
      end
    end
  end

  task automatic push_op(logic [2:0] op, logic [7:0] b, logic [7:0] n, bit first, bit fault,
                         logic [15:0] maxlen);
    item_t it;
    it.operation = op;
    it.data_byte = b;
    it.frame_length = n;
    it.first_of_frame = first;
    it.is_fault = fault;
    it.drop_amount = $urandom;
    it.max_read_len = maxlen;
    pending_items_q.push_back(it);
    items_queued++;
  endtask

  task automatic push_frame(int unsigned n, bit fault, int unsigned sent, int fault_code);
    for (int unsigned i = 0; i < sent; i++)
      push_op(OP_FRAME, (i == 3 && fault_code >= 0) ? fault_code[7:0] : 8'($urandom),
              (i == 0) ? n[7:0] : 8'($urandom), i == 0, (i == 0) ? fault : $urandom_range(0, 1),
              $urandom);
  endtask

  task automatic push_reads(int n, logic [15:0] maxlen);
    repeat (n) push_op(OP_READ, $urandom, $urandom, $urandom_range(0, 1),
                       $urandom_range(0, 1), maxlen);
  endtask

  task automatic push_drops(logic [31:0] amount);
    push_op(OP_DROPS, $urandom, $urandom, $urandom_range(0, 1), $urandom_range(0, 1), $urandom);
    pending_items_q[$].drop_amount = amount;
  endtask

  task automatic push_random_frame(bit fault);
    int unsigned n, sent;
    case ($urandom_range(0, 19))
      0: n = 0;
      1: n = $urandom_range(65, 255);
      2: n = MAXFB;
      default: n = $urandom_range(1, 10);
    endcase
    sent = (n == 0 || n > MAXFB) ? $urandom_range(1, 3) : n;
    case ($urandom_range(0, 7))
      0: sent = $urandom_range(1, sent);
      1: sent = sent + $urandom_range(1, 2);
      default: ;
    endcase
    push_frame(n, fault, sent, -1);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_PRE: pre_lim = val[7:0];
      REG_POST: post_lim = val[7:0];
      REG_REASON: reason_reg = val[7:0];
      REG_HASH: hash_reg = val;
      REG_KIND: kind_reg = val[7:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (pending_items_q.size() != 0 || expected_results_q.size() != 0 || s_axis_tvalid)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_limit();
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd1;
      default: return $urandom_range(1, 8);
    endcase
  endfunction

  initial begin
    pre_lim = 8'd16; post_lim = 8'd16; reason_reg = '0; hash_reg = '0; kind_reg = '0;
    clear_capture();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: special cases with a small capture
    write_reg(REG_PRE, 2);
    write_reg(REG_POST, 3);
    write_reg(REG_REASON, 32'hA5);
    write_reg(REG_HASH, 32'h89AB_CDEF);
    write_reg(REG_KIND, 32'h5A);
    push_reads(1, 16'hFFFF);
    push_op(OP_SNAP, 8'hFF, 0, 0, 0, 0);
    push_op(OP_FRAME, 8'h11, 8'd0, 1, 0, 0);
    push_op(OP_FRAME, 8'h22, 8'd5, 0, 0, 0);
    push_drops(32'hFFFF_FFFF);
    push_drops(32'd2);
    push_op(OP_RSVD5, 8'h00, 0, 0, 0, 0);
    push_op(OP_RSVD6, 8'hFF, 8'hFF, 1, 1, 16'hFFFF);
    push_op(OP_RSVD7, 8'h55, 0, 0, 0, 0);
    push_frame(3, 0, 3, -1);
    push_frame(6, 1, 7, 8'hC3);
    push_op(OP_SNAP, 8'h00, 0, 0, 0, 0);
    push_op(OP_SNAP, 8'hFF, 0, 0, 0, 0);
    push_frame(4, 0, 2, -1);
    push_frame(2, 0, 2, -1);
    push_frame(2, 0, 2, -1);
    push_reads(1, 16'd5);
    push_reads(42, 16'hFFFF);
    push_op(OP_CLEAR, 0, 0, 0, 0, 0);
    push_frame(2, 1, 2, -1);
    push_reads(2, 16'hFFFF);
    wait_idle();

    // length store overflow before and after the fault
    write_reg(REG_PRE, 255);
    write_reg(REG_POST, 255);
    push_op(OP_CLEAR, 0, 0, 0, 0, 0);
    repeat (MAXFR + 3) push_frame(1, 0, 1, -1);
    push_frame(1, 1, 1, -1);
    repeat (4) push_frame(1, 0, 1, -1);
    push_reads(30, 16'hFFFF);
    push_op(OP_CLEAR, 0, 0, 0, 0, 0);
    wait_idle();

    // ring space overflow; long receiver hold fills the block meanwhile
    hold_req++;
    repeat (17) push_frame(MAXFB, 0, MAXFB, -1);
    push_frame(5, 1, 5, -1);
    push_reads(40, 16'hFFFF);
    push_op(OP_CLEAR, 0, 0, 0, 0, 0);
    wait_idle();

    while (items_queued < ITEM_GOAL) begin
      write_reg(REG_PRE, pick_limit());
      write_reg(REG_POST, pick_limit());
      write_reg(REG_REASON, $urandom);
      write_reg(REG_HASH, ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : $urandom);
      write_reg(REG_KIND, $urandom);
      if ($urandom_range(0, 1)) push_op(OP_CLEAR, $urandom, $urandom, 0, 0, $urandom);
      repeat ($urandom_range(0, 10)) begin
        push_random_frame(0);
        if ($urandom_range(0, 5) == 0) push_drops($urandom);
      end
      if ($urandom_range(0, 7) == 0)
        push_frame($urandom_range(1, 3), 1, $urandom_range(1, 3), -1);
      else
        push_frame($urandom_range(4, 10), 1, $urandom_range(4, 10), $urandom);
      repeat ($urandom_range(0, 36)) push_op(OP_SNAP, $urandom, $urandom, 0, 0, $urandom);
      repeat ($urandom_range(0, 6)) push_random_frame($urandom_range(0, 1));
      if ($urandom_range(0, 3) == 0) push_op($urandom_range(5, 7), $urandom, $urandom,
                                             $urandom_range(0, 1), $urandom_range(0, 1),
                                             $urandom);
      if ($urandom_range(0, 4) == 0) push_reads(2, $urandom);
      push_reads($urandom_range(20, 140), 16'hFFFF);
      wait_idle();
    end

    if (fails == 0 && expected_results_q.size() == 0)
      $display("[fault_trace_capsule_buffer_top] OK");
    else
      $display("[fault_trace_capsule_buffer_top] ERROR");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[fault_trace_capsule_buffer_top] ERROR");
    $finish;
  end

endmodule
